FILE: rtl/u2a_pkg.sv
// Shared types, register indexes and mapping functions for the UTF-8 to
// ASCII transliterator. Used by u2a_decode, u2a_outq and the top level.
// No dependencies.
package u2a_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SUBSTITUTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;

  localparam logic [7:0] BYTE_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] out_char;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [1:0]  cont_left;
    logic [20:0] accum;
    logic [6:0]  ch;
  } dec_t;

  // Folds a code point below U+0180 to an ASCII letter; zero if none.
  function automatic logic [6:0] fold_letter(input logic [8:0] u);
    logic [6:0] f;
    f = 7'h00;
    case (u) inside
      [9'h0C0:9'h0C6], 9'h102, 9'h104:           f = 7'h41; // A
      9'h0C7, 9'h106, 9'h10C:                    f = 7'h43; // C
      [9'h0C8:9'h0CB], 9'h118, 9'h11A:           f = 7'h45; // E
      [9'h0CC:9'h0CF]:                           f = 7'h49; // I
      9'h0D0, 9'h10E, 9'h110:                    f = 7'h44; // D
      9'h0D1, 9'h143, 9'h147:                    f = 7'h4E; // N
      [9'h0D2:9'h0D6], 9'h0D8, 9'h150:           f = 7'h4F; // O
      [9'h0D9:9'h0DC], 9'h16E, 9'h170:           f = 7'h55; // U
      9'h0DD, 9'h178:                            f = 7'h59; // Y
      9'h0DE, 9'h164:                            f = 7'h54; // T
      9'h0DF:                                    f = 7'h73; // s
      [9'h0E0:9'h0E6], 9'h103:                   f = 7'h61; // a
      9'h0E7, 9'h107:                            f = 7'h63; // c
      [9'h0E8:9'h0EB], 9'h119, 9'h11B:           f = 7'h65; // e
      [9'h0EC:9'h0EF]:                           f = 7'h69; // i
      9'h0F0, 9'h111, 9'h10F:                    f = 7'h64; // d
      9'h0F1, 9'h144, 9'h148:                    f = 7'h6E; // n
      [9'h0F2:9'h0F6], 9'h0F8, 9'h151:           f = 7'h6F; // o
      [9'h0F9:9'h0FC], 9'h16F, 9'h171:           f = 7'h75; // u
      9'h0FD, 9'h0FF:                            f = 7'h79; // y
      9'h0FE, 9'h163:                            f = 7'h74; // t
      9'h141, 9'h13D, 9'h139:                    f = 7'h4C; // L
      9'h142, 9'h13E, 9'h13A:                    f = 7'h6C; // l
      9'h154, 9'h158:                            f = 7'h52; // R
      9'h155, 9'h159:                            f = 7'h72; // r
      9'h160, 9'h15E:                            f = 7'h53; // S
      9'h161, 9'h15F:                            f = 7'h73; // s
      9'h179, 9'h17B, 9'h17D:                    f = 7'h5A; // Z
      9'h17A, 9'h17C, 9'h17E:                    f = 7'h7A; // z
      default:                                   f = 7'h00;
    endcase
    return f;
  endfunction

  // Maps a complete code point to its output character; zero for nothing.
  function automatic logic [6:0] map_code_point(input logic [20:0] u,
                                                input logic [6:0]  subst,
                                                input logic        prev_space);
    logic       small_cp;
    logic [6:0] f;
    logic [6:0] r;
    small_cp = (u < 21'h000180);
    f = fold_letter(u[8:0]);
    if (subst != 7'h00 && ((u >= 21'h20 && u <= 21'h7E) || u == 21'h09 || u == 21'h0A)) begin
      r = u[6:0];
    end else if ((u >= 21'h30 && u <= 21'h39) || (u >= 21'h41 && u <= 21'h5A) ||
                 (u >= 21'h61 && u <= 21'h7A) || u == 21'h5F) begin
      r = u[6:0];
    end else if (u == 21'h20) begin
      r = prev_space ? 7'h00 : 7'h5F;
    end else if (!small_cp) begin
      r = 7'h00;
    end else if (f != 7'h00) begin
      r = f;
    end else begin
      r = subst;
    end
    return r;
  endfunction

endpackage

FILE: rtl/u2a_decode.sv
// UTF-8 sequence decoder and character mapper: next sequence state and the
// character that one byte gives. Depends on u2a_pkg.
module u2a_decode (
  input  logic [7:0]    in_byte,
  input  logic [1:0]    cont_left,
  input  logic [20:0]   accum,
  input  logic [6:0]    subst,
  input  logic          prev_space,
  output u2a_pkg::dec_t dec
);

  logic [1:0]  cont_n;
  logic [20:0] acc_n;
  logic        consumed;
  logic        complete;
  logic [20:0] cp;

  always_comb begin
    cont_n   = cont_left;
    acc_n    = accum;
    consumed = 1'b0;
    complete = 1'b0;
    cp       = 21'd0;

    if (cont_left != 2'd0) begin
      if (in_byte[7:6] == 2'b10) begin
        acc_n    = {accum[14:0], in_byte[5:0]};
        cont_n   = cont_left - 2'd1;
        consumed = 1'b1;
        if (cont_n == 2'd0) begin
          complete = 1'b1;
          cp       = acc_n;
        end
      end else begin
        // A fresh byte breaks the partial sequence and is decoded anew.
        cont_n = 2'd0;
        acc_n  = 21'd0;
      end
    end

    if (!consumed) begin
      case (in_byte) inside
        [8'h01:8'h7F]: begin
          complete = 1'b1;
          cp       = {13'd0, in_byte};
        end
        [8'hC2:8'hDF]: begin
          acc_n  = {16'd0, in_byte[4:0]};
          cont_n = 2'd1;
        end
        [8'hE0:8'hEF]: begin
          acc_n  = {17'd0, in_byte[3:0]};
          cont_n = 2'd2;
        end
        [8'hF0:8'hF7]: begin
          acc_n  = {18'd0, in_byte[2:0]};
          cont_n = 2'd3;
        end
        default: begin
        end
      endcase
    end

    dec.cont_left = cont_n;
    dec.accum     = acc_n;
    dec.ch        = complete ? u2a_pkg::map_code_point(cp, subst, prev_space) : 7'h00;
  end

endmodule

FILE: rtl/u2a_outq.sv
// Two-entry result queue that separates the decode side from the receiver.
// Depends on u2a_pkg.
module u2a_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u2a_pkg::out_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output u2a_pkg::out_t out_data
);

  u2a_pkg::out_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic [1:0]    count_nxt;
  logic          pop;

  assign pop       = out_valid && !out_stall;
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/utf8_to_ascii_transliterate_core.sv
// Top level of the UTF-8 to ASCII transliterator: stream state, counting
// and configuration. Depends on u2a_pkg, u2a_decode and u2a_outq.
//
// Usage: bytes of a string arrive on the in_ channel (valid/stall), the
// final byte flagged by end_of_string. Each request is decoded in the
// cycle it is accepted and its result, if any, is written into a two-entry
// queue that drives the out_ channel. A byte gives a result when it emits
// a character or ends the string, unless the length limit has been
// reached; last marks the end of a string's output. One byte is accepted
// every cycle; in_stall rises only when both queue entries hold results
// that the receiver has not yet taken, so sustained throughput follows
// the receiver, up to one request per cycle.
// The cfg_ port writes substitute_char (index 0) and max_length (index 1);
// other indexes are ignored. Writes belong between strings.
// Synchronous reset clears both registers, the stream state and the queue.
// While out_stall is high the head result holds steady.
module utf8_to_ascii_transliterate_core #(
  parameter int COUNT_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  u2a_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output u2a_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [u2a_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [u2a_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [6:0]            sub_r;
  logic [7:0]            maxlen_r;
  logic [1:0]            cont_r;
  logic [20:0]           acc_r;
  logic                  prev_space_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  lim_r;

  u2a_pkg::dec_t         dec;
  u2a_pkg::out_t         push_data;
  logic                  in_acc;
  logic                  eos;
  logic                  emit;
  logic                  push;
  logic                  q_full;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                  hit;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;
  assign eos      = in_data.end_of_string;

  u2a_decode u_decode (
    .in_byte    (in_data.in_byte),
    .cont_left  (cont_r),
    .accum      (acc_r),
    .subst      (sub_r),
    .prev_space (prev_space_r),
    .dec        (dec)
  );

  assign emit    = (dec.ch != 7'h00);
  assign cnt_nxt = (cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign hit     = emit && (maxlen_r != 8'd0) && (CMP_W'(cnt_nxt) == CMP_W'(maxlen_r));
  assign push    = in_acc && !lim_r && (emit || eos);

  assign push_data.char_valid = emit;
  assign push_data.out_char   = dec.ch;
  assign push_data.last       = eos || hit;

  u2a_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r        <= 7'h00;
      maxlen_r     <= 8'h00;
      cont_r       <= 2'd0;
      acc_r        <= 21'd0;
      prev_space_r <= 1'b0;
      cnt_r        <= '0;
      lim_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          u2a_pkg::REG_SUBSTITUTE: sub_r    <= cfg_data[6:0];
          u2a_pkg::REG_MAX_LENGTH: maxlen_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        if (eos) begin
          // The end of a string returns the stream state to its start.
          cont_r       <= 2'd0;
          acc_r        <= 21'd0;
          prev_space_r <= 1'b0;
          cnt_r        <= '0;
          lim_r        <= 1'b0;
        end else if (!lim_r) begin
          cont_r       <= dec.cont_left;
          acc_r        <= dec.accum;
          prev_space_r <= (in_data.in_byte == u2a_pkg::BYTE_SPACE) && (sub_r == 7'h00);
          if (emit) begin
            cnt_r <= cnt_nxt;
          end
          if (hit) begin
            lim_r <= 1'b1;
          end
        end
      end
    end
  end

`ifndef SYNTH
  a_no_push_after_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && lim_r) |-> !push)
    else $error("result produced after the length limit was reached");

  a_eos_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && eos) |=> (cont_r == 2'd0 && cnt_r == '0 && !lim_r && !prev_space_r))
    else $error("stream state not cleared after end of string");

  a_empty_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.char_valid || out_data.last))
    else $error("result without a character does not close the string");

  a_limit_set_by_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(lim_r) |-> $past(push && push_data.last && push_data.char_valid))
    else $error("limit reached without a closing character");

  a_eos_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && eos && !lim_r) |=> out_valid)
    else $error("end of string produced no result");
`endif

endmodule
